// ----- rtl/bss_pkg.sv -----
// shared widths, defaults and register codes of the bezier segment sampler
package bss_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 1024;
	localparam int unsigned POS_W  = 16;
	localparam int unsigned WEND_W = 17;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CTRL_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CTRL_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_CTRL_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_CTRL_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_END_X         = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y         = 3'd7;

endpackage

// ----- rtl/bss_if.sv -----
// sample and result channel interfaces of the bezier segment sampler
interface bss_sample_if import bss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  sample_index;
	logic [POS_W-1:0]  window_start;
	logic [WEND_W-1:0] window_end;

	modport source (output valid, sample_index, window_start, window_end, input ready);
	modport sink (input valid, sample_index, window_start, window_end, output ready);
endinterface

interface bss_result_if import bss_pkg::*; #(
	parameter int unsigned SLOT_W = 10
) ();
	logic                    valid;
	logic                    ready;
	logic [SLOT_W-1:0]       write_slot;
	logic signed [VAL_W-1:0] write_value;
	logic                    last_write;

	modport source (output valid, write_slot, write_value, last_write, input ready);
	modport sink (input valid, write_slot, write_value, last_write, output ready);
endinterface

// ----- rtl/bezier_segment_sampler.sv -----
// bezier segment sampler: evaluates a cubic segment per sample and repairs a window buffer
//
// Usage: the eight segment registers (start, two control points, end; x and y each)
// are written over cfg_write/cfg_index/cfg_data while the block is idle. Each sample
// transfer on the sample channel carries a sample position and an output window.
// The block works on one sample at a time; sample.ready is high only when it is idle.
// A sample gives zero, one or two transfers on the result channel, the final one
// marked by last_write. A sample outside the window gives no result and the block
// is ready again in the next cycle.
// Steps: a sample inside the segment needs a serial division for t, then the weights
// and sums on the shared 34 x 31 multiplier; then the block places the point, checks
// the slot and loads the output register. An interpolating repair adds a second
// division, an extrapolating one (slot above one) a multiplier product. At either end
// of the segment no division runs. The block is ready again in the cycle after its
// last result is loaded.
// Reset: the WINDOW_DEPTH buffer entries (1024 by default) are swept to zero at one entry
// per cycle while sample.ready stays low; registers take their reset values.
// A stalled receiver holds the output register; the block waits with the buffer
// write until the output register is free, so no result is lost.
module bezier_segment_sampler import bss_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	bss_sample_if.sink           sample,
	bss_result_if.source         result
);

	localparam int unsigned AW      = $clog2(WINDOW_DEPTH);
	localparam int unsigned MA_W    = 34;
	localparam int unsigned MB_W    = 31;
	localparam int unsigned P_W     = MA_W + MB_W + 1;
	localparam int unsigned DNUM_W  = 34;
	localparam int unsigned DDEN_W  = 17;
	localparam logic [5:0]  DIV_STEPS = 6'd34;
	localparam logic [WEND_W-1:0] DEPTH_V = WEND_W'(WINDOW_DEPTH);

	// sequencer states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_TDIV  = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_XPOS  = 4'd4;
	localparam logic [3:0] S_CHECK = 4'd5;
	localparam logic [3:0] S_EMIT1 = 4'd6;
	localparam logic [3:0] S_RD1   = 4'd7;
	localparam logic [3:0] S_RD2   = 4'd8;
	localparam logic [3:0] S_CALC  = 4'd9;
	localparam logic [3:0] S_QDIV  = 4'd10;
	localparam logic [3:0] S_XMUL  = 4'd11;
	localparam logic [3:0] S_EMIT2 = 4'd12;

	// multiplier operation tags
	localparam logic [3:0] TAG_TT  = 4'd0;
	localparam logic [3:0] TAG_MM  = 4'd1;
	localparam logic [3:0] TAG_W3  = 4'd2;
	localparam logic [3:0] TAG_W0  = 4'd3;
	localparam logic [3:0] TAG_W1  = 4'd4;
	localparam logic [3:0] TAG_W2  = 4'd5;
	localparam logic [3:0] TAG_Y0  = 4'd6;
	localparam logic [3:0] TAG_Y1  = 4'd7;
	localparam logic [3:0] TAG_Y2  = 4'd8;
	localparam logic [3:0] TAG_Y3  = 4'd9;
	localparam logic [3:0] TAG_X0  = 4'd10;
	localparam logic [3:0] TAG_X1  = 4'd11;
	localparam logic [3:0] TAG_X2  = 4'd12;
	localparam logic [3:0] TAG_X3  = 4'd13;
	localparam logic [3:0] TAG_EXT = 4'd14;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [P_W-1:0] v);
		logic signed [P_W-1:0] hi;
		logic signed [P_W-1:0] lo;
		hi = P_W'(64'sd2147483647);
		lo = -P_W'(64'sd2147483648);
		if (v > hi) return 32'sh7fffffff;
		else if (v < lo) return 32'sh80000000;
		else return v[VAL_W-1:0];
	endfunction

	function automatic logic [MB_W-1:0] round_w(input logic [49:0] r);
		logic [49:0] s;
		s = r + 50'd131072;
		return s[48:18];
	endfunction

	// configuration registers
	logic [POS_W-1:0]        sx_q, c1x_q, c2x_q, ex_q;
	logic signed [VAL_W-1:0] sy_q, c1y_q, c2y_q, ey_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q  <= '0;
			c1x_q <= '0;
			c2x_q <= '0;
			ex_q  <= POS_W'(1);
			sy_q  <= '0;
			c1y_q <= '0;
			c2y_q <= '0;
			ey_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START_X:       sx_q  <= cfg_data[POS_W-1:0];
				REG_START_Y:       sy_q  <= cfg_data;
				REG_FIRST_CTRL_X:  c1x_q <= cfg_data[POS_W-1:0];
				REG_FIRST_CTRL_Y:  c1y_q <= cfg_data;
				REG_SECOND_CTRL_X: c2x_q <= cfg_data[POS_W-1:0];
				REG_SECOND_CTRL_Y: c2y_q <= cfg_data;
				REG_END_X:         ex_q  <= cfg_data[POS_W-1:0];
				REG_END_Y:         ey_q  <= cfg_data;
			endcase
		end
	end

	logic [3:0]  state_q;
	logic [AW-1:0] clr_q;
	logic [3:0]  step_q;
	logic        dir_q;
	logic        neg_q;
	logic [AW-1:0] slot_q, span_m1_q, tx_q;
	logic [POS_W-1:0] slot_ws_q;
	logic [16:0] t_q;
	logic [32:0] t2_q, m2_q;
	logic [MB_W-1:0] w0_q, w1_q, w2_q, w3_q;
	logic signed [63:0] acc_y_q;
	logic [49:0] acc_x_q;
	logic signed [VAL_W-1:0] y_q, prev_q, val_q;
	logic signed [VAL_W-1:0] rd_data_q;

	// window span and slot of an incoming sample
	logic [WEND_W-1:0] span_raw, span_sat;
	logic [POS_W-1:0]  slot_raw;
	logic              in_window;
	logic [AW-1:0]     span_m1;

	always_comb begin
		if (sample.window_end <= WEND_W'(sample.window_start)) span_raw = WEND_W'(1);
		else span_raw = sample.window_end - WEND_W'(sample.window_start);
		span_sat = (span_raw > DEPTH_V) ? DEPTH_V : span_raw;
		span_m1 = AW'(span_sat - WEND_W'(1));
		slot_raw = sample.sample_index - sample.window_start;
		in_window = (sample.sample_index >= sample.window_start)
			&& (WEND_W'(slot_raw) < span_sat);
	end

	// curve parameter cases
	logic [POS_W-1:0]  wd;
	logic [DNUM_W-1:0] t_num;
	logic              t_zero, t_one;

	always_comb begin
		wd = ex_q - sx_q;
		t_num = DNUM_W'({sample.sample_index - sx_q, 16'h0000}) + DNUM_W'(wd >> 1);
		t_zero = (ex_q <= sx_q) || (sample.sample_index <= sx_q);
		t_one = sample.sample_index >= ex_q;
	end

	logic [16:0] mt;
	assign mt = 17'h10000 - t_q;

	// serial restoring divider, one quotient bit per cycle
	logic [5:0]        div_cnt_q;
	logic [DNUM_W-1:0] div_num_q;
	logic [DDEN_W-1:0] div_den_q;
	logic [DDEN_W-1:0] div_rem_q;
	logic [DDEN_W:0]   rem_sh;
	logic              rem_ge;
	logic [DDEN_W:0]   rem_nx;

	always_comb begin
		rem_sh = {div_rem_q, div_num_q[DNUM_W-1]};
		rem_ge = rem_sh >= {1'b0, div_den_q};
		rem_nx = rem_ge ? rem_sh - {1'b0, div_den_q} : rem_sh;
	end

	// repair arithmetic from buffer data
	logic [AW-1:0] k_up, k_dn;
	logic signed [32:0] d_int, d_ext;
	logic [32:0] d_abs;

	always_comb begin
		k_up = tx_q - slot_q;
		k_dn = slot_q - tx_q;
		d_int = 33'(y_q) - 33'(prev_q);
		d_ext = 33'(prev_q) - 33'(rd_data_q);
		d_abs = d_int[32] ? 33'(-d_int) : 33'(d_int);
	end

	// shared multiplier: operand selection by tag
	logic              mul_issue;
	logic [3:0]        mul_tag;
	logic signed [MA_W-1:0] mul_a;
	logic [MB_W-1:0]   mul_b;
	logic signed [P_W-1:0]  prod_s1;
	logic [3:0]        ptag_s1;
	logic              pv_s1;

	always_comb begin
		mul_issue = 1'b0;
		mul_tag = step_q;
		if (state_q == S_MUL && step_q <= TAG_X3) mul_issue = 1'b1;
		if (state_q == S_CALC && tx_q < slot_q && slot_q > AW'(1)) begin
			mul_issue = 1'b1;
			mul_tag = TAG_EXT;
		end
		unique case (mul_tag)
			TAG_TT:  begin mul_a = MA_W'(t_q);  mul_b = MB_W'(t_q);  end
			TAG_MM:  begin mul_a = MA_W'(mt);   mul_b = MB_W'(mt);   end
			TAG_W3:  begin mul_a = MA_W'(t2_q); mul_b = MB_W'(t_q);  end
			TAG_W0:  begin mul_a = MA_W'(m2_q); mul_b = MB_W'(mt);   end
			TAG_W1:  begin mul_a = MA_W'(m2_q); mul_b = MB_W'(t_q);  end
			TAG_W2:  begin mul_a = MA_W'(t2_q); mul_b = MB_W'(mt);   end
			TAG_Y0:  begin mul_a = MA_W'(sy_q);  mul_b = w0_q; end
			TAG_Y1:  begin mul_a = MA_W'(c1y_q); mul_b = w1_q; end
			TAG_Y2:  begin mul_a = MA_W'(c2y_q); mul_b = w2_q; end
			TAG_Y3:  begin mul_a = MA_W'(ey_q);  mul_b = w3_q; end
			TAG_X0:  begin mul_a = MA_W'(sx_q);  mul_b = w0_q; end
			TAG_X1:  begin mul_a = MA_W'(c1x_q); mul_b = w1_q; end
			TAG_X2:  begin mul_a = MA_W'(c2x_q); mul_b = w2_q; end
			TAG_X3:  begin mul_a = MA_W'(ex_q);  mul_b = w3_q; end
			TAG_EXT: begin mul_a = MA_W'(d_ext); mul_b = MB_W'(k_dn); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// product register and the tag it belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= mul_issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * $signed({1'b0, mul_b});
		ptag_s1 <= mul_tag;
	end

	// product consumption into weights and sums
	logic [49:0] p3;
	assign p3 = 50'(prod_s1[47:0]) + {prod_s1[48:0], 1'b0};

	always_ff @(posedge clk) begin
		if (pv_s1) begin
			unique case (ptag_s1)
				TAG_TT:  t2_q <= prod_s1[32:0];
				TAG_MM:  m2_q <= prod_s1[32:0];
				TAG_W3:  w3_q <= round_w(prod_s1[49:0]);
				TAG_W0:  w0_q <= round_w(prod_s1[49:0]);
				TAG_W1:  w1_q <= round_w(p3);
				TAG_W2:  w2_q <= round_w(p3);
				TAG_Y0:  acc_y_q <= prod_s1[63:0];
				TAG_Y1, TAG_Y2, TAG_Y3: acc_y_q <= acc_y_q + prod_s1[63:0];
				TAG_X0:  acc_x_q <= prod_s1[49:0];
				TAG_X1, TAG_X2, TAG_X3: acc_x_q <= acc_x_q + prod_s1[49:0];
				default: ;
			endcase
		end
	end

	// curve point from the sums
	logic signed [64:0] ys_rnd, ys_sh;
	logic signed [VAL_W-1:0] y_sat;
	logic [49:0] xs_rnd;
	logic [19:0] xr, xd;
	logic [AW-1:0] tx_c;

	always_comb begin
		ys_rnd = $signed({acc_y_q[63], acc_y_q}) + 65'sd536870912;
		ys_sh = ys_rnd >>> 30;
		y_sat = sat32(P_W'(ys_sh));
		xs_rnd = acc_x_q + 50'd536870912;
		xr = xs_rnd[49:30];
		xd = xr - 20'(slot_ws_q);
		if (xr < 20'(slot_ws_q) || xd > 20'(span_m1_q)) tx_c = span_m1_q;
		else tx_c = xd[AW-1:0];
	end

	// repaired values
	logic signed [35:0] qsum;
	logic signed [45:0] esum;

	always_comb begin
		qsum = neg_q ? 36'(prev_q) - $signed({2'b00, div_num_q})
			: 36'(prev_q) + $signed({2'b00, div_num_q});
		esum = 46'(y_q) + $signed(prod_s1[45:0]);
	end

	// output register and buffer port
	logic out_v_q;
	logic out_free;
	logic emit;
	logic [AW-1:0] emit_slot;
	logic signed [VAL_W-1:0] emit_val;
	logic emit_last;
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic signed [VAL_W-1:0] mem_wd;

	assign out_free = !out_v_q || result.ready;

	always_comb begin
		emit = 1'b0;
		emit_slot = slot_q;
		emit_val = y_q;
		emit_last = 1'b1;
		if (state_q == S_EMIT1 && out_free) begin
			emit = 1'b1;
			emit_slot = dir_q ? slot_q : tx_q;
			emit_last = dir_q;
		end
		if (state_q == S_EMIT2 && out_free) begin
			emit = 1'b1;
			emit_val = val_q;
		end
		mem_we = emit || state_q == S_CLEAR;
		mem_wa = (state_q == S_CLEAR) ? clr_q : emit_slot;
		mem_wd = (state_q == S_CLEAR) ? '0 : emit_val;
		unique case (state_q)
			S_RD1:   mem_ra = slot_q - AW'(1);
			S_RD2:   mem_ra = slot_q - AW'(2);
			default: mem_ra = slot_q;
		endcase
	end

	// window buffer memory
	logic signed [VAL_W-1:0] window_buf_q [WINDOW_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) window_buf_q[mem_wa] <= mem_wd;
		rd_data_q <= window_buf_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result.write_slot  <= emit_slot;
			result.write_value <= emit_val;
			result.last_write  <= emit_last;
		end
	end

	assign result.valid = out_v_q;
	assign sample.ready = state_q == S_IDLE;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			step_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			if (div_cnt_q != 6'd0) div_cnt_q <= div_cnt_q - 6'd1;
			if (mul_issue && state_q == S_MUL) step_q <= step_q + 4'd1;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(WINDOW_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (sample.valid && in_window) begin
						step_q <= TAG_TT;
						if (t_zero || t_one) begin
							state_q <= S_MUL;
						end else begin
							div_cnt_q <= DIV_STEPS;
							state_q <= S_TDIV;
						end
					end
				end
				S_TDIV: if (div_cnt_q == 6'd0) state_q <= S_MUL;
				S_MUL:   if (pv_s1 && ptag_s1 == TAG_X3) state_q <= S_XPOS;
				S_XPOS:  state_q <= S_CHECK;
				S_CHECK: begin
					if (tx_q == slot_q || slot_q == '0) state_q <= S_EMIT1;
					else if (rd_data_q != '0) state_q <= S_IDLE;
					else state_q <= S_EMIT1;
				end
				S_EMIT1: if (out_free) state_q <= dir_q ? S_IDLE : S_RD1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_CALC;
				S_CALC: begin
					if (tx_q > slot_q) begin
						div_cnt_q <= DIV_STEPS;
						state_q <= S_QDIV;
					end else if (slot_q > AW'(1)) begin
						state_q <= S_XMUL;
					end else begin
						state_q <= S_EMIT2;
					end
				end
				S_QDIV:  if (div_cnt_q == 6'd0) state_q <= S_EMIT2;
				S_XMUL:  if (pv_s1 && ptag_s1 == TAG_EXT) state_q <= S_EMIT2;
				S_EMIT2: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath registers
	always_ff @(posedge clk) begin
		if (div_cnt_q != 6'd0) begin
			div_num_q <= {div_num_q[DNUM_W-2:0], rem_ge};
			div_rem_q <= rem_nx[DDEN_W-1:0];
		end
		unique case (state_q)
			S_IDLE: begin
				slot_q    <= slot_raw[AW-1:0];
				span_m1_q <= span_m1;
				slot_ws_q <= sample.window_start;
				t_q <= t_zero ? 17'd0 : 17'h10000;
				div_num_q <= t_num;
				div_den_q <= DDEN_W'(wd);
				div_rem_q <= '0;
			end
			S_TDIV: if (div_cnt_q == 6'd0) t_q <= div_num_q[16:0];
			S_XPOS: begin
				y_q  <= y_sat;
				tx_q <= tx_c;
			end
			S_CHECK: dir_q <= (tx_q == slot_q) || (slot_q == '0);
			S_RD2:   prev_q <= rd_data_q;
			S_CALC: begin
				neg_q <= d_int[32];
				div_num_q <= DNUM_W'(d_abs) + DNUM_W'(k_up);
				div_den_q <= DDEN_W'({k_up, 1'b0});
				div_rem_q <= '0;
				val_q <= y_q;
			end
			S_QDIV:  if (div_cnt_q == 6'd0) val_q <= sat32(P_W'(qsum));
			S_XMUL:  if (pv_s1 && ptag_s1 == TAG_EXT) val_q <= sat32(P_W'(esum));
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ext_only_in_xmul: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 && ptag_s1 == TAG_EXT |-> state_q == S_XMUL)
		else $error("extrapolation product outside its wait state");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q != 6'd0 |-> (state_q == S_TDIV || state_q == S_QDIV))
		else $error("divider running outside a division state");
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !result.valid || $past(result.valid))
		else $error("result appeared right after a sample transfer");
`endif

endmodule
